FILE: hdl/phase_unwrap_linear_fit_macros.svh
// ---------------------------------------------------------------------------
// Phase unwrap line fit assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PHASE_UNWRAP_LINEAR_FIT_MACROS_SVH
`define PHASE_UNWRAP_LINEAR_FIT_MACROS_SVH
`ifndef SYNTHESIS
`define PLF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("phase_unwrap_linear_fit assertion failed");
`define PLF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("phase_unwrap_linear_fit assertion failed");
`else
`define PLF_ASSERT(lbl, prop)
`define PLF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/plf_pkg.sv
// ---------------------------------------------------------------------------
// Phase unwrap line fit package
// Shared widths, constants and request types.
// ---------------------------------------------------------------------------
`default_nettype none
package plf_pkg;
  localparam int PHASE_W      = 16;
  localparam int IDX_W        = 12;
  localparam int CNT_W        = 13;
  localparam int M_W          = 13;
  localparam int MAX_CHANNELS = 4096;
  localparam int MAX_OUT      = 4096;
  localparam int PREV_W       = 32;
  localparam int SY_W         = 42;
  localparam int SXY_W        = 54;
  localparam int SLOPE_W      = 48;
  localparam int OFF_W        = 56;
  localparam int FIT_W        = 48;
  localparam int DEN_W        = 37;
  localparam int DIVD_W       = 80;
  localparam int Q_DEPTH      = 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [PHASE_W-1:0] phase;
    logic                      last;
    logic [IDX_W-1:0]          out_index;
  } plf_in_t;

  typedef struct packed {
    logic signed [FIT_W-1:0] fitted_phase;
    logic                    fit_valid;
  } plf_out_t;

  typedef struct packed {
    logic                      is_query;
    logic                      is_fit;
    logic signed [PHASE_W-1:0] phase;
    logic [IDX_W-1:0]          out_index;
  } plf_cmd_t;
endpackage
`default_nettype wire

FILE: hdl/plf_front.sv
// ---------------------------------------------------------------------------
// Phase unwrap line fit front end
// Accepts requests into a short queue and classifies them for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module plf_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire plf_pkg::plf_in_t in_item_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output plf_pkg::plf_cmd_t     cmd_o
);
  import plf_pkg::*;

  plf_in_t     mem_q [Q_DEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;
  plf_in_t     head;

  assign full        = (cnt_q == 2'(Q_DEPTH));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_push     = push && !full;
  assign do_pop      = cmd_valid_o && cmd_ready_i;
  assign head        = mem_q[rd_ptr_q];

  always_comb begin
    cmd_o.is_query  = (head.kind == KIND_QUERY);
    cmd_o.is_fit    = (head.kind == KIND_LOAD) && head.last;
    cmd_o.phase     = head.phase;
    cmd_o.out_index = head.out_index;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/plf_div.sv
// ---------------------------------------------------------------------------
// Phase unwrap line fit divider
// Restoring divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module plf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [plf_pkg::DIVD_W-1:0]    dividend_i,
  input  wire logic [plf_pkg::DEN_W-1:0]     divisor_i,
  output logic                               done_o,
  output logic [plf_pkg::DIVD_W-1:0]         quo_o,
  output logic [plf_pkg::DEN_W-1:0]          rem_o
);
  import plf_pkg::*;

  logic [DIVD_W-1:0] quo_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic [6:0]        cnt_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial  = {rem_q, quo_q[DIVD_W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/plf_back.sv
// ---------------------------------------------------------------------------
// Phase unwrap line fit back end
// Unwraps and accumulates samples, sequences the fit and evaluates queries.
// ---------------------------------------------------------------------------
`default_nettype none
module plf_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cmd_valid_i,
  output logic                          cmd_ready_o,
  input  wire plf_pkg::plf_cmd_t        cmd_i,
  input  wire logic [plf_pkg::M_W-1:0]  m_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output plf_pkg::plf_out_t             res_o
);
  import plf_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIT_A   = 4'd1;
  localparam logic [3:0] S_FIT_B   = 4'd2;
  localparam logic [3:0] S_DIV1_GO = 4'd3;
  localparam logic [3:0] S_DIV1    = 4'd4;
  localparam logic [3:0] S_OFF_LO  = 4'd5;
  localparam logic [3:0] S_OFF_HI  = 4'd6;
  localparam logic [3:0] S_DIV2_GO = 4'd7;
  localparam logic [3:0] S_DIV2    = 4'd8;
  localparam logic [3:0] S_QMUL    = 4'd9;
  localparam logic [3:0] S_QOUT    = 4'd10;

  localparam logic [63:0] QCLAMP = 64'h0000_4000_0000_0000;

  function automatic logic signed [63:0] round_fin(input logic neg,
      input logic [DIVD_W-1:0] q, input logic [DEN_W-1:0] r,
      input logic [DEN_W-1:0] den, input logic sh16);
    logic [DIVD_W-1:0] qc;
    logic              frac;
    logic [63:0]       mag;
    qc = q;
    if (sh16) begin
      if (q[DIVD_W-1:16] > QCLAMP) qc = {QCLAMP, q[15:0]};
    end else if (q > DIVD_W'(QCLAMP)) begin
      qc = DIVD_W'(QCLAMP);
    end
    frac = ({r, 1'b0} >= {1'b0, den});
    mag  = qc[63:0] + 64'(frac);
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] sat_w(input logic signed [63:0] v,
      input int w);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  logic [3:0]                state_q;
  logic signed [PREV_W-1:0]  prev_q;
  logic [CNT_W-1:0]          count_q;
  logic signed [SY_W-1:0]    sy_q;
  logic signed [SXY_W-1:0]   sxy_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic signed [OFF_W-1:0]   offset_q;
  logic                      fit_ready_q;
  logic signed [63:0]        prod_a_q, acc_q;
  logic [25:0]               prod_b_q, prod_c_q;
  logic signed [26:0]        k_q;
  logic [DEN_W-1:0]          den_q;
  logic                      neg_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [60:0]        qprod_q;

  logic                      div_start, div_done;
  logic [DIVD_W-1:0]         div_dividend, div_quo;
  logic [DEN_W-1:0]          div_rem;
  logic [63:0]               acc_mag;

  logic signed [32:0]        d;
  logic [32:0]               dmag;
  logic signed [17:0]        rs;
  logic signed [PREV_W-1:0]  p;
  logic signed [63:0]        qv;

  plf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign acc_mag      = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign div_start    = (state_q == S_DIV1_GO) || (state_q == S_DIV2_GO);
  assign div_dividend = (state_q == S_DIV1_GO) ? {acc_mag, 16'd0} : {16'd0, acc_mag};
  assign cmd_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_QOUT) && res_ready_i;

  always_comb begin
    d    = 33'(cmd_i.phase) - 33'(prev_q);
    dmag = d[32] ? 33'(-d) : 33'(d);
    rs   = d[32] ? -$signed({2'b00, dmag[15:0]}) : $signed({2'b00, dmag[15:0]});
    p    = prev_q + PREV_W'(rs);
    if (rs < -18'sd32768) p = p + 32'sd65536;
    else if (rs > 18'sd32768) p = p - 32'sd65536;
  end

  always_comb begin
    qv = 64'(qprod_q) + 64'(offset_q) + 64'sd32768;
    res_o.fit_valid    = fit_ready_q;
    res_o.fitted_phase = fit_ready_q ? FIT_W'(sat_w(qv >>> 16, FIT_W)) : '0;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        idx_q <= cmd_i.out_index;
      end
      S_FIT_A: begin
        prod_a_q <= 64'($signed({1'b0, CNT_W'(count_q - 1'b1)}) * sy_q);
        prod_b_q <= 26'(m_i * CNT_W'(count_q - 1'b1));
        prod_c_q <= 26'(m_i * count_q);
      end
      S_FIT_B: begin
        acc_q <= 64'sd6 * ((64'(sxy_q) <<< 1) - prod_a_q);
        den_q <= DEN_W'(prod_b_q * 14'(count_q + 1'b1));
        k_q   <= $signed({13'd0, m_i, 1'b0}) - $signed({14'd0, count_q})
               - $signed({1'b0, prod_c_q});
      end
      S_DIV1_GO, S_DIV2_GO: begin
        neg_q <= acc_q[63];
      end
      S_OFF_LO: begin
        acc_q <= 64'($signed({1'b0, slope_q[23:0]}) * k_q);
      end
      S_OFF_HI: begin
        acc_q <= acc_q + (64'($signed(slope_q[47:24]) * k_q) <<< 24)
               + (64'(sy_q) <<< 17);
        den_q <= DEN_W'({count_q, 1'b0});
      end
      S_QMUL: begin
        qprod_q <= 61'($signed({1'b0, idx_q}) * slope_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      count_q     <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      slope_q     <= '0;
      offset_q    <= '0;
      fit_ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.is_query) begin
              state_q <= S_QMUL;
            end else begin
              if (count_q == '0) fit_ready_q <= 1'b0;
              if (count_q < CNT_W'(MAX_CHANNELS)) begin
                sy_q    <= sy_q + SY_W'(p);
                sxy_q   <= sxy_q + SXY_W'(p * $signed({1'b0, count_q}));
                count_q <= count_q + 1'b1;
                prev_q  <= p;
              end
              if (cmd_i.is_fit) state_q <= S_FIT_A;
            end
          end
        end
        S_FIT_A: state_q <= S_FIT_B;
        S_FIT_B: begin
          if (count_q < CNT_W'(2)) begin
            slope_q <= '0;
            state_q <= S_OFF_LO;
          end else begin
            state_q <= S_DIV1_GO;
          end
        end
        S_DIV1_GO: state_q <= S_DIV1;
        S_DIV1: begin
          if (div_done) begin
            slope_q <= SLOPE_W'(sat_w(round_fin(neg_q, div_quo, div_rem, den_q, 1'b1),
                                      SLOPE_W));
            state_q <= S_OFF_LO;
          end
        end
        S_OFF_LO: begin
          if (count_q == '0) begin
            offset_q    <= '0;
            fit_ready_q <= 1'b1;
            prev_q      <= '0;
            sy_q        <= '0;
            sxy_q       <= '0;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_OFF_HI;
          end
        end
        S_OFF_HI:  state_q <= S_DIV2_GO;
        S_DIV2_GO: state_q <= S_DIV2;
        S_DIV2: begin
          if (div_done) begin
            offset_q    <= OFF_W'(sat_w(round_fin(neg_q, div_quo, div_rem, den_q, 1'b0),
                                        OFF_W));
            fit_ready_q <= 1'b1;
            prev_q      <= '0;
            count_q     <= '0;
            sy_q        <= '0;
            sxy_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_QMUL: state_q <= S_QOUT;
        S_QOUT: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/phase_unwrap_linear_fit.sv
// ---------------------------------------------------------------------------
// Phase unwrap line fit
// Unwraps phase samples, fits a least-squares line and answers queries.
//
// Channel   Handshake              Payload
// input     push / full            in_item_i (kind, phase, last, out_index)
// result    empty / pop            out_item_o (fitted_phase, fit_valid)
// config    psel/penable/pwrite    paddr, pwdata, prdata (output channel count)
//
// A load sample is taken only while the back end is idle, so loads stream at
// one per cycle between fits and queries. A fit runs two 80-step serial
// divisions, the first skipped below two samples; a query passes through its
// multiply and output stages. Reset clears all control state, the sums and
// the fit; the queues on both sides let input and result stall independently.
// ---------------------------------------------------------------------------
`default_nettype none
`include "phase_unwrap_linear_fit_macros.svh"
module phase_unwrap_linear_fit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire plf_pkg::plf_in_t  in_item_i,
  output logic                   empty,
  input  wire logic              pop,
  output plf_pkg::plf_out_t      out_item_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import plf_pkg::*;

  logic [M_W-1:0] m_q, m_eff;
  logic           cmd_valid, cmd_ready;
  plf_cmd_t       cmd;
  logic           res_valid, res_ready;
  plf_out_t       res;
  plf_out_t       oq_mem_q [Q_DEPTH];
  logic           oq_wr_q, oq_rd_q;
  logic [1:0]     oq_cnt_q;
  logic           oq_pop;

  assign pready = 1'b1;
  assign prdata = {{(32 - M_W){1'b0}}, m_q};
  assign m_eff  = (m_q == '0) ? M_W'(1) : ((m_q > M_W'(MAX_OUT)) ? M_W'(MAX_OUT) : m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= M_W'(1);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      m_q <= pwdata[M_W-1:0];
    end
  end

  plf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  plf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .m_i         (m_eff),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready  = (oq_cnt_q != 2'(Q_DEPTH));
  assign empty      = (oq_cnt_q == 2'd0);
  assign oq_pop     = pop && !empty;
  assign out_item_o = oq_mem_q[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      oq_mem_q[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (res_valid) oq_wr_q <= ~oq_wr_q;
      if (oq_pop) oq_rd_q <= ~oq_rd_q;
      oq_cnt_q <= oq_cnt_q + 2'(res_valid) - 2'(oq_pop);
    end
  end

  `PLF_ASSERT(a_oq_bound, oq_cnt_q <= 2'(Q_DEPTH))
  `PLF_ASSERT(a_no_overflow, res_valid |-> oq_cnt_q != 2'(Q_DEPTH))
  `PLF_ASSERT(a_pop_drains, (oq_pop && !res_valid) |=> oq_cnt_q == $past(oq_cnt_q) - 2'd1)
endmodule
`default_nettype wire
